// ----- src/wbg_pkg.sv -----
// Package for the white-balance gain calculator.
// Field structs, register codes, reset values and divider chain sizes.
// No dependencies.
package wbg_pkg;

  // field widths
  localparam int MeasW   = 8;
  localparam int GainW   = 16;
  localparam int CfgW    = 16;
  localparam int CfgIdxW = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_GOLDEN_RED   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_GOLDEN_GREEN = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_GOLDEN_BLUE  = 2'd2;

  // register reset values
  localparam logic [CfgW-1:0] GOLDEN_RED_RST   = 16'd620;
  localparam logic [CfgW-1:0] GOLDEN_GREEN_RST = 16'd1024;
  localparam logic [CfgW-1:0] GOLDEN_BLUE_RST  = 16'd719;

  // gain of 1.0 and correction ratio of 1.0
  localparam logic [GainW-1:0] UNITY_GAIN = 16'h0100;
  localparam int               RatioOne   = 512;
  // 0x100 * 512, numerator of the green gain
  localparam int               GreenNum   = 131072;

  // divider phases: current and golden ratios, correction ratios, gains
  localparam int ANumW  = 26;
  localparam int ADenW  = 16;
  localparam int ALanes = 4;
  localparam int BNumW  = 35;
  localparam int BDenW  = 16;
  localparam int BLanes = 2;
  localparam int CNumW  = 43;
  localparam int CDenW  = 35;
  localparam int CLanes = 4;

  // registers from accept to strobe: all division cells plus the output register
  localparam int PipeLat = ANumW + BNumW + CNumW + 1;

  typedef struct packed {
    logic [MeasW-1:0] red_meas;
    logic [MeasW-1:0] green_red_meas;
    logic [MeasW-1:0] green_blue_meas;
    logic [MeasW-1:0] blue_meas;
  } in_t;

  typedef struct packed {
    logic [GainW-1:0] red_gain;
    logic [GainW-1:0] green_gain;
    logic [GainW-1:0] blue_gain;
    logic             gains_valid;
    logic             divide_error;
  } out_t;

  // side data riding along the last divider phase
  typedef struct packed {
    logic             err;
    logic             rr_ge;
    logic             br_ge;
    logic             rr_zero;
    logic             br_zero;
    logic [GainW-1:0] rr_half;
    logic [GainW-1:0] br_half;
  } sb_c_t;

endpackage

// ----- src/wbg_div_cell.sv -----
// One restoring-division cell: settles one quotient bit for every lane.
// Depends on nothing; instantiated in a row by wbg_div_chain.
module wbg_div_cell #(
  parameter int NUM_W = 26,
  parameter int DEN_W = 16,
  parameter int LANES = 4,
  parameter int SB_W  = 1,
  parameter int BIT   = 0
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              vld_in,
  input  logic [LANES-1:0][NUM_W-1:0]       num_in,
  input  logic [LANES-1:0][DEN_W-1:0]       den_in,
  input  logic [LANES-1:0][DEN_W-1:0]       rem_in,
  input  logic [LANES-1:0][NUM_W-1:0]       quo_in,
  input  logic [SB_W-1:0]                   sb_in,
  output logic                              vld_out,
  output logic [LANES-1:0][NUM_W-1:0]       num_out,
  output logic [LANES-1:0][DEN_W-1:0]       den_out,
  output logic [LANES-1:0][DEN_W-1:0]       rem_out,
  output logic [LANES-1:0][NUM_W-1:0]       quo_out,
  output logic [SB_W-1:0]                   sb_out
);

  logic [LANES-1:0][DEN_W:0]   trial;
  logic [LANES-1:0][DEN_W:0]   diff;
  logic [LANES-1:0]            ge;
  logic [LANES-1:0][DEN_W-1:0] rem_next;
  logic [LANES-1:0][NUM_W-1:0] quo_next;

  // shift in the next numerator bit, subtract when it fits
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      trial[l]       = {rem_in[l], num_in[l][BIT]};
      diff[l]        = trial[l] - {1'b0, den_in[l]};
      ge[l]          = trial[l] >= {1'b0, den_in[l]};
      rem_next[l]    = ge[l] ? diff[l][DEN_W-1:0] : trial[l][DEN_W-1:0];
      quo_next[l]    = quo_in[l];
      quo_next[l][BIT] = ge[l];
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else begin
      vld_out <= vld_in;
    end
  end

  // payload hand-off to the next cell
  always_ff @(posedge clk) begin
    num_out <= num_in;
    den_out <= den_in;
    rem_out <= rem_next;
    quo_out <= quo_next;
    sb_out  <= sb_in;
  end

endmodule

// ----- src/wbg_div_chain.sv -----
// Row of division cells, one quotient bit per cell, MSB first.
// Depends on wbg_pkg and wbg_div_cell.
module wbg_div_chain #(
  parameter int NUM_W = wbg_pkg::ANumW,
  parameter int DEN_W = wbg_pkg::ADenW,
  parameter int LANES = wbg_pkg::ALanes,
  parameter int SB_W  = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        vld_in,
  input  logic [LANES-1:0][NUM_W-1:0] num_in,
  input  logic [LANES-1:0][DEN_W-1:0] den_in,
  input  logic [SB_W-1:0]             sb_in,
  output logic                        vld_out,
  output logic [LANES-1:0][NUM_W-1:0] quo_out,
  output logic [LANES-1:0][DEN_W-1:0] rem_out,
  output logic [SB_W-1:0]             sb_out
);

  logic [NUM_W:0]                          vld_s;
  logic [NUM_W:0][LANES-1:0][NUM_W-1:0]    num_s;
  logic [NUM_W:0][LANES-1:0][DEN_W-1:0]    den_s;
  logic [NUM_W:0][LANES-1:0][DEN_W-1:0]    rem_s;
  logic [NUM_W:0][LANES-1:0][NUM_W-1:0]    quo_s;
  logic [NUM_W:0][SB_W-1:0]                sb_s;

  // chain entry: empty remainder and quotient
  assign vld_s[0] = vld_in;
  assign num_s[0] = num_in;
  assign den_s[0] = den_in;
  assign rem_s[0] = '0;
  assign quo_s[0] = '0;
  assign sb_s[0]  = sb_in;

  for (genvar k = 0; k < NUM_W; k++) begin : g_cell
    wbg_div_cell #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W),
      .LANES (LANES),
      .SB_W  (SB_W),
      .BIT   (NUM_W - 1 - k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .vld_in  (vld_s[k]),
      .num_in  (num_s[k]),
      .den_in  (den_s[k]),
      .rem_in  (rem_s[k]),
      .quo_in  (quo_s[k]),
      .sb_in   (sb_s[k]),
      .vld_out (vld_s[k+1]),
      .num_out (num_s[k+1]),
      .den_out (den_s[k+1]),
      .rem_out (rem_s[k+1]),
      .quo_out (quo_s[k+1]),
      .sb_out  (sb_s[k+1])
    );
  end

  // numerator and divisor are spent at the end of the row
  logic unused_tail;
  assign unused_tail = ^{num_s[NUM_W], den_s[NUM_W]};

  assign vld_out = vld_s[NUM_W] | (unused_tail & 1'b0);
  assign quo_out = quo_s[NUM_W];
  assign rem_out = rem_s[NUM_W];
  assign sb_out  = sb_s[NUM_W];

endmodule

// ----- src/white_balance_gain_calc.sv -----
// White-balance gain calculator, top level.
// Depends on wbg_pkg and wbg_div_chain (rows of wbg_div_cell).
//
//  channel  | ports                          | transfer
//  ---------+--------------------------------+-------------------------------
//  item in  | start, busy, item (in_t)       | edge with start high, busy low
//  result   | done, result (out_t)           | edge ending the done cycle
//  config   | cfg_we, cfg_index, cfg_data    | edge with cfg_we high
//
// One item enters per cycle; busy stays low outside reset handling.
// A result strobes after its item has passed three rows of division cells
// (26, 35 and 43 cells, one quotient bit each) and the output register.
// Reset (rst, synchronous) empties the pipeline and restores the golden
// values. The receiver cannot stall; results leave on done unconditionally.
module white_balance_gain_calc (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  wbg_pkg::in_t                 item,
  output logic                         done,
  output wbg_pkg::out_t                result,
  input  logic                         cfg_we,
  input  logic [wbg_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [wbg_pkg::CfgW-1:0]     cfg_data
);

  localparam int GW = wbg_pkg::GainW;

  logic [wbg_pkg::CfgW-1:0] golden_red;
  logic [wbg_pkg::CfgW-1:0] golden_green;
  logic [wbg_pkg::CfgW-1:0] golden_blue;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      golden_red   <= wbg_pkg::GOLDEN_RED_RST;
      golden_green <= wbg_pkg::GOLDEN_GREEN_RST;
      golden_blue  <= wbg_pkg::GOLDEN_BLUE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wbg_pkg::REG_GOLDEN_RED:   golden_red   <= cfg_data;
        wbg_pkg::REG_GOLDEN_GREEN: golden_green <= cfg_data;
        wbg_pkg::REG_GOLDEN_BLUE:  golden_blue  <= cfg_data;
        default: ;
      endcase
    end
  end

  // no transfer is taken while reset is held
  assign busy = rst;

  // phase A: current R/G, B/G and golden R/G, B/G
  logic [wbg_pkg::MeasW:0]                           gsum;
  logic [wbg_pkg::MeasW-1:0]                         gmean;
  logic [wbg_pkg::ALanes-1:0][wbg_pkg::ANumW-1:0]    num_a;
  logic [wbg_pkg::ALanes-1:0][wbg_pkg::ADenW-1:0]    den_a;
  logic                                              err_a;
  logic                                              vld_a;
  logic [wbg_pkg::ALanes-1:0][wbg_pkg::ANumW-1:0]    quo_a;
  logic [wbg_pkg::ALanes-1:0][wbg_pkg::ADenW-1:0]    rem_a;
  logic                                              err_a_out;

  assign gsum  = {1'b0, item.green_red_meas} + {1'b0, item.green_blue_meas};
  assign gmean = gsum[wbg_pkg::MeasW:1];
  assign err_a = (gmean == '0) || (golden_green == '0);
  assign num_a[0] = wbg_pkg::ANumW'({item.red_meas, 10'd0});
  assign num_a[1] = wbg_pkg::ANumW'({item.blue_meas, 10'd0});
  assign num_a[2] = {golden_red, 10'd0};
  assign num_a[3] = {golden_blue, 10'd0};
  assign den_a[0] = wbg_pkg::ADenW'(gmean);
  assign den_a[1] = wbg_pkg::ADenW'(gmean);
  assign den_a[2] = golden_green;
  assign den_a[3] = golden_green;

  wbg_div_chain #(
    .NUM_W (wbg_pkg::ANumW),
    .DEN_W (wbg_pkg::ADenW),
    .LANES (wbg_pkg::ALanes),
    .SB_W  (1)
  ) u_chain_a (
    .clk     (clk),
    .rst     (rst),
    .vld_in  (start && !busy),
    .num_in  (num_a),
    .den_in  (den_a),
    .sb_in   (err_a),
    .vld_out (vld_a),
    .quo_out (quo_a),
    .rem_out (rem_a),
    .sb_out  (err_a_out)
  );

  // phase B: correction ratios golden/current scaled by 512
  logic [GW-1:0]                                     rg;
  logic [GW-1:0]                                     bg;
  logic [wbg_pkg::BLanes-1:0][wbg_pkg::BNumW-1:0]    num_b;
  logic [wbg_pkg::BLanes-1:0][wbg_pkg::BDenW-1:0]    den_b;
  logic                                              err_b;
  logic                                              vld_b;
  logic [wbg_pkg::BLanes-1:0][wbg_pkg::BNumW-1:0]    quo_b;
  logic [wbg_pkg::BLanes-1:0][wbg_pkg::BDenW-1:0]    rem_b;
  logic                                              err_b_out;

  assign rg       = quo_a[0][GW-1:0];
  assign bg       = quo_a[1][GW-1:0];
  assign err_b    = err_a_out || (rg == '0) || (bg == '0);
  assign num_b[0] = {quo_a[2], 9'd0};
  assign num_b[1] = {quo_a[3], 9'd0};
  assign den_b[0] = rg;
  assign den_b[1] = bg;

  wbg_div_chain #(
    .NUM_W (wbg_pkg::BNumW),
    .DEN_W (wbg_pkg::BDenW),
    .LANES (wbg_pkg::BLanes),
    .SB_W  (1)
  ) u_chain_b (
    .clk     (clk),
    .rst     (rst),
    .vld_in  (vld_a),
    .num_in  (num_b),
    .den_in  (den_b),
    .sb_in   (err_b),
    .vld_out (vld_b),
    .quo_out (quo_b),
    .rem_out (rem_b),
    .sb_out  (err_b_out)
  );

  // phase C: every gain quotient either branch may need
  logic [wbg_pkg::BNumW-1:0]                         rr;
  logic [wbg_pkg::BNumW-1:0]                         br;
  wbg_pkg::sb_c_t                                    sb_c;
  logic [wbg_pkg::CLanes-1:0][wbg_pkg::CNumW-1:0]    num_c;
  logic [wbg_pkg::CLanes-1:0][wbg_pkg::CDenW-1:0]    den_c;
  logic                                              vld_c;
  logic [wbg_pkg::CLanes-1:0][wbg_pkg::CNumW-1:0]    quo_c;
  logic [wbg_pkg::CLanes-1:0][wbg_pkg::CDenW-1:0]    rem_c;
  logic [$bits(wbg_pkg::sb_c_t)-1:0]                 sb_c_out;

  assign rr = quo_b[0];
  assign br = quo_b[1];
  assign sb_c.err     = err_b_out;
  assign sb_c.rr_ge   = rr >= wbg_pkg::BNumW'(wbg_pkg::RatioOne);
  assign sb_c.br_ge   = br >= wbg_pkg::BNumW'(wbg_pkg::RatioOne);
  assign sb_c.rr_zero = rr == '0;
  assign sb_c.br_zero = br == '0;
  assign sb_c.rr_half = rr[GW:1];
  assign sb_c.br_half = br[GW:1];
  // lanes: 256*rr/br, 131072/br, 256*br/rr, 131072/rr
  assign num_c[0] = {rr, 8'd0};
  assign num_c[1] = wbg_pkg::CNumW'(wbg_pkg::GreenNum);
  assign num_c[2] = {br, 8'd0};
  assign num_c[3] = wbg_pkg::CNumW'(wbg_pkg::GreenNum);
  assign den_c[0] = br;
  assign den_c[1] = br;
  assign den_c[2] = rr;
  assign den_c[3] = rr;

  wbg_div_chain #(
    .NUM_W (wbg_pkg::CNumW),
    .DEN_W (wbg_pkg::CDenW),
    .LANES (wbg_pkg::CLanes),
    .SB_W  ($bits(wbg_pkg::sb_c_t))
  ) u_chain_c (
    .clk     (clk),
    .rst     (rst),
    .vld_in  (vld_b),
    .num_in  (num_c),
    .den_in  (den_c),
    .sb_in   (sb_c),
    .vld_out (vld_c),
    .quo_out (quo_c),
    .rem_out (rem_c),
    .sb_out  (sb_c_out)
  );

  // remainders are not needed by any phase
  logic rem_unused;
  assign rem_unused = ^{rem_a, rem_b, rem_c};

  // branch selection: pin the channel needing least boost at unity
  wbg_pkg::sb_c_t sbf;
  wbg_pkg::out_t  res_next;
  logic           err_f;
  logic           red_pin;
  logic           blue_pin;
  logic [GW-1:0]  rgain;
  logic [GW-1:0]  ggain;
  logic [GW-1:0]  bgain;

  always_comb begin
    sbf      = wbg_pkg::sb_c_t'(sb_c_out);
    err_f    = sbf.err;
    red_pin  = 1'b0;
    blue_pin = 1'b0;
    rgain    = '0;
    ggain    = '0;
    bgain    = '0;
    if (!err_f) begin
      priority if (sbf.rr_ge && sbf.br_ge) begin
        rgain = sbf.rr_half;
        ggain = wbg_pkg::UNITY_GAIN;
        bgain = sbf.br_half;
      end else if (sbf.rr_ge) begin
        blue_pin = 1'b1;
      end else if (sbf.br_ge) begin
        red_pin = 1'b1;
      end else if (sbf.rr_zero || sbf.br_zero) begin
        err_f = 1'b1;
      end else if (quo_c[3][GW-1:0] >= quo_c[1][GW-1:0]) begin
        red_pin = 1'b1;
      end else begin
        blue_pin = 1'b1;
      end
    end
    if (blue_pin) begin
      if (sbf.br_zero) begin
        err_f = 1'b1;
      end else begin
        rgain = quo_c[0][GW-1:0];
        ggain = quo_c[1][GW-1:0];
        bgain = wbg_pkg::UNITY_GAIN;
      end
    end else if (red_pin) begin
      if (sbf.rr_zero) begin
        err_f = 1'b1;
      end else begin
        rgain = wbg_pkg::UNITY_GAIN;
        ggain = quo_c[3][GW-1:0];
        bgain = quo_c[2][GW-1:0];
      end
    end
    if (err_f) begin
      rgain = '0;
      ggain = '0;
      bgain = '0;
    end
    res_next.red_gain     = rgain;
    res_next.green_gain   = ggain;
    res_next.blue_gain    = bgain;
    res_next.gains_valid  = !err_f && (rgain != '0) && (ggain != '0) && (bgain != '0);
    res_next.divide_error = err_f | (rem_unused & 1'b0);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld_c;
    end
  end

  always_ff @(posedge clk) begin
    result <= res_next;
  end

  // checks
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(wbg_pkg::PipeLat) done)
    else $error("result strobe missing after fixed latency");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.divide_error) |->
      (result.red_gain == '0 && result.green_gain == '0 && result.blue_gain == '0))
    else $error("gains nonzero on divide error");

  a_valid_no_err: assert property (@(posedge clk) disable iff (rst)
    (done && result.gains_valid) |-> !result.divide_error)
    else $error("valid flag set with divide error");

  a_unity_pin: assert property (@(posedge clk) disable iff (rst)
    (done && !result.divide_error) |->
      (result.red_gain == wbg_pkg::UNITY_GAIN || result.green_gain == wbg_pkg::UNITY_GAIN ||
       result.blue_gain == wbg_pkg::UNITY_GAIN))
    else $error("no channel pinned at unity gain");

endmodule

// ----- test/tb_top.sv -----
// Testbench for white_balance_gain_calc: directed and random calibration bytes
// under several golden settings, checked against an in-bench gain predictor.
// Depends on wbg_pkg and the white_balance_gain_calc RTL.
`timescale 1ns / 100ps

module tb_top;

  localparam int WatchLimit = 4000;
  localparam int DrainWait  = wbg_pkg::PipeLat + 10;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic                         busy;
  wbg_pkg::in_t                 item = '0;
  logic                         done;
  wbg_pkg::out_t                result;
  logic                         cfg_we = 1'b0;
  logic [wbg_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [wbg_pkg::CfgW-1:0]     cfg_data = '0;

  // golden values as the block should hold them
  logic [wbg_pkg::CfgW-1:0] gold_red   = wbg_pkg::GOLDEN_RED_RST;
  logic [wbg_pkg::CfgW-1:0] gold_green = wbg_pkg::GOLDEN_GREEN_RST;
  logic [wbg_pkg::CfgW-1:0] gold_blue  = wbg_pkg::GOLDEN_BLUE_RST;

  wbg_pkg::out_t pending_gains[$];
  int   err_count = 0;
  int   sent_count = 0;
  int   checked_count = 0;
  int   divide_err_seen = 0;
  int   idle_pct = 0;
  int   quiet_cycles = 0;

  always #1 clk = ~clk;

  white_balance_gain_calc u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // gains for one module's bytes under the current golden values
  function automatic wbg_pkg::out_t predict_gains(wbg_pkg::in_t m);
    longint unsigned gmean, cur_rg, cur_bg, gold_rg, gold_bg, rr, br, pin_r, pin_b;
    longint unsigned rg_out, gg_out, bg_out;
    bit err, red_pin, blue_pin;
    wbg_pkg::out_t o;
    err = 0; red_pin = 0; blue_pin = 0;
    rg_out = 0; gg_out = 0; bg_out = 0;
    gmean = (longint'(m.green_red_meas) + longint'(m.green_blue_meas)) >> 1;
    if (gmean == 0 || gold_green == 0) begin
      err = 1;
    end else begin
      cur_rg  = (longint'(m.red_meas) * 1024 / gmean) & 16'hFFFF;
      cur_bg  = (longint'(m.blue_meas) * 1024 / gmean) & 16'hFFFF;
      gold_rg = 1024 * longint'(gold_red) / longint'(gold_green);
      gold_bg = 1024 * longint'(gold_blue) / longint'(gold_green);
      if (cur_rg == 0 || cur_bg == 0) begin
        err = 1;
      end else begin
        rr = wbg_pkg::RatioOne * gold_rg / cur_rg;
        br = wbg_pkg::RatioOne * gold_bg / cur_bg;
        if (rr >= wbg_pkg::RatioOne && br >= wbg_pkg::RatioOne) begin
          rg_out = (256 * rr / wbg_pkg::RatioOne) & 16'hFFFF;
          gg_out = wbg_pkg::UNITY_GAIN;
          bg_out = (256 * br / wbg_pkg::RatioOne) & 16'hFFFF;
        end else if (rr >= wbg_pkg::RatioOne) begin
          blue_pin = 1;
        end else if (br >= wbg_pkg::RatioOne) begin
          red_pin = 1;
        end else if (rr == 0 || br == 0) begin
          err = 1;
        end else begin
          // both below one: pin red when its green gain is at least blue's, else blue
          pin_r = (wbg_pkg::GreenNum / rr) & 16'hFFFF;
          pin_b = (wbg_pkg::GreenNum / br) & 16'hFFFF;
          if (pin_r >= pin_b) red_pin = 1;
          else blue_pin = 1;
        end
        if (blue_pin) begin
          if (br == 0) err = 1;
          else begin
            rg_out = (256 * rr / br) & 16'hFFFF;
            gg_out = (wbg_pkg::GreenNum / br) & 16'hFFFF;
            bg_out = wbg_pkg::UNITY_GAIN;
          end
        end else if (red_pin) begin
          if (rr == 0) err = 1;
          else begin
            rg_out = wbg_pkg::UNITY_GAIN;
            gg_out = (wbg_pkg::GreenNum / rr) & 16'hFFFF;
            bg_out = (256 * br / rr) & 16'hFFFF;
          end
        end
      end
    end
    if (err) begin
      rg_out = 0; gg_out = 0; bg_out = 0;
    end
    o.red_gain     = rg_out[wbg_pkg::GainW-1:0];
    o.green_gain   = gg_out[wbg_pkg::GainW-1:0];
    o.blue_gain    = bg_out[wbg_pkg::GainW-1:0];
    o.gains_valid  = !err && rg_out != 0 && gg_out != 0 && bg_out != 0;
    o.divide_error = err;
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    err_count++;
    $display("MISMATCH t=%0t %s: got %0h want %0h", $time, what, got, want);
  endtask

  // compare each strobed result with the oldest prediction
  always @(posedge clk) begin
    wbg_pkg::out_t want;
    if (!rst && done) begin
      if (pending_gains.size() == 0) begin
        report_mismatch("result with none pending", 1, 0);
      end else begin
        want = pending_gains.pop_front();
        checked_count++;
        if (want.divide_error) divide_err_seen++;
        if (result.red_gain != want.red_gain)
          report_mismatch("red_gain", int'(result.red_gain), int'(want.red_gain));
        if (result.green_gain != want.green_gain)
          report_mismatch("green_gain", int'(result.green_gain), int'(want.green_gain));
        if (result.blue_gain != want.blue_gain)
          report_mismatch("blue_gain", int'(result.blue_gain), int'(want.blue_gain));
        if (result.gains_valid != want.gains_valid)
          report_mismatch("gains_valid", int'(result.gains_valid),
                          int'(want.gains_valid));
        if (result.divide_error != want.divide_error)
          report_mismatch("divide_error", int'(result.divide_error),
                          int'(want.divide_error));
      end
    end
  end

  // watchdog: cycles with neither an item transfer nor a result
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // one item transfer, with random idle cycles ahead of it
  task automatic send_bytes(logic [7:0] r, logic [7:0] gr, logic [7:0] gb,
                            logic [7:0] b);
    wbg_pkg::in_t m;
    m = '{red_meas: r, green_red_meas: gr, green_blue_meas: gb, blue_meas: b};
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item  <= m;
    forever begin
      @(negedge clk);
      if (!busy) break;
      @(posedge clk);
    end
    @(posedge clk);
    pending_gains.push_back(predict_gains(m));
    sent_count++;
  endtask

  // stop sending and wait for every prediction to be met
  task automatic drain;
    start <= 1'b0;
    while (pending_gains.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [wbg_pkg::CfgIdxW-1:0] idx,
                           logic [wbg_pkg::CfgW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      wbg_pkg::REG_GOLDEN_RED:   gold_red   = val;
      wbg_pkg::REG_GOLDEN_GREEN: gold_green = val;
      wbg_pkg::REG_GOLDEN_BLUE:  gold_blue  = val;
      default: ;
    endcase
  endtask

  task automatic set_golden(logic [wbg_pkg::CfgW-1:0] r, logic [wbg_pkg::CfgW-1:0] g,
                            logic [wbg_pkg::CfgW-1:0] b);
    drain();
    write_reg(wbg_pkg::REG_GOLDEN_RED, r);
    write_reg(wbg_pkg::REG_GOLDEN_GREEN, g);
    write_reg(wbg_pkg::REG_GOLDEN_BLUE, b);
  endtask

  // byte patterns that hit each branch and zero divisors from the bytes
  task automatic test_directed;
    send_bytes(8'd0, 8'd0, 8'd0, 8'd0);        // zero green mean
    send_bytes(8'd255, 8'd1, 8'd0, 8'd255);    // green mean truncates to zero
    send_bytes(8'd255, 8'd255, 8'd255, 8'd255);
    send_bytes(8'd0, 8'd128, 8'd128, 8'd100);  // red ratio zero
    send_bytes(8'd100, 8'd128, 8'd128, 8'd0);  // blue ratio zero
    send_bytes(8'd40, 8'd200, 8'd200, 8'd50);  // both corrections above one
    send_bytes(8'd200, 8'd100, 8'd100, 8'd30); // red high, blue low
    send_bytes(8'd30, 8'd100, 8'd100, 8'd200); // red low, blue high
    send_bytes(8'd200, 8'd90, 8'd90, 8'd220);  // both below one
    send_bytes(8'd220, 8'd90, 8'd90, 8'd200);
    send_bytes(8'd1, 8'd255, 8'd255, 8'd1);    // large gains
    send_bytes(8'd255, 8'd1, 8'd2, 8'd255);
    send_bytes(8'd77, 8'd128, 8'd128, 8'd90);  // near the golden ratios
  endtask

  // golden extremes, a zero golden green, and a write to the unused index
  task automatic test_golden_extremes;
    set_golden(16'd0, 16'd1024, 16'd719);      // zero red correction
    send_bytes(8'd60, 8'd128, 8'd128, 8'd60);
    send_bytes(8'd60, 8'd128, 8'd128, 8'd200);
    set_golden(16'd620, 16'd0, 16'd719);       // golden green zero
    send_bytes(8'd60, 8'd128, 8'd128, 8'd60);
    set_golden(16'hFFFF, 16'd1, 16'hFFFF);
    send_bytes(8'd1, 8'd255, 8'd255, 8'd1);
    send_bytes(8'd255, 8'd1, 8'd1, 8'd255);
    set_golden(16'd1, 16'hFFFF, 16'd0);
    send_bytes(8'd255, 8'd1, 8'd1, 8'd255);
    send_bytes(8'd10, 8'd200, 8'd200, 8'd10);
    drain();
    write_reg(2'd3, 16'hA5A5);                 // no register there
    send_bytes(8'd128, 8'd128, 8'd128, 8'd128);
  endtask

  // random bytes: mostly plausible modules, some wild values and zeros
  task automatic test_random(int count, int pct, bit pause_midway);
    logic [7:0] r, gr, gb, b, gmid;
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      if (pause_midway && i == count / 2) drain();
      case ($urandom_range(9))
        0, 1: begin
          r = 8'($urandom); gr = 8'($urandom); gb = 8'($urandom); b = 8'($urandom);
        end
        2: begin
          r = 8'($urandom_range(3)); gr = 8'($urandom_range(3));
          gb = 8'($urandom_range(3)); b = 8'($urandom_range(3));
        end
        default: begin
          gmid = 8'($urandom_range(255, 40));
          gr = 8'(gmid + $urandom_range(8) - 4);
          gb = 8'(gmid + $urandom_range(8) - 4);
          r = 8'($urandom_range(255, 10));
          b = 8'($urandom_range(255, 10));
        end
      endcase
      send_bytes(r, gr, gb, b);
    end
  endtask

  task automatic random_golden;
    logic [wbg_pkg::CfgW-1:0] g;
    g = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2000, 300));
    if (g == 0) g = 1;
    set_golden(($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1500, 200)),
               g,
               ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1500, 200)));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    idle_pct = 18;
    test_directed();
    test_golden_extremes();
    set_golden(wbg_pkg::GOLDEN_RED_RST, wbg_pkg::GOLDEN_GREEN_RST,
               wbg_pkg::GOLDEN_BLUE_RST);
    test_random(300, 18, 1'b0);
    random_golden();
    test_random(350, 18, 1'b0);
    random_golden();
    test_random(650, 56, 1'b0);
    random_golden();
    test_random(650, 0, 1'b1);

    drain();
    repeat (DrainWait) @(posedge clk);
    $display("Covered %0d items, %0d results checked (%0d divide errors),",
             sent_count, checked_count, divide_err_seen);
    $display("across reset, extreme and random golden values and three idle mixes.");
    if (err_count == 0 && pending_gains.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
